// File: hw/rtl/lcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared constants, types and register codes of the LBA to CHS read-command
// sequencer.
// ----------------------------------------------------------------------------
package lcs_pkg;

    localparam int BLOCK_BITS = 26;
    localparam int DVS_W      = 6;
    localparam int STEP_BITS  = 4;
    localparam int DIV_STAGES = (BLOCK_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_W      = DIV_STAGES * STEP_BITS;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [7:0] DRVHD_BASE       = 8'hA0;
    localparam logic [7:0] HEAD_MASK        = 8'h0F;
    localparam logic [7:0] SECTOR_COUNT_ONE = 8'h01;

    localparam logic [4:0] HEAD_COUNT_RST   = 5'd16;
    localparam logic [5:0] SPT_RST          = 6'd63;
    localparam logic [7:0] READ_CMD_RST     = 8'h20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAD_COUNT   = 3'd0,
        CFG_SPT          = 3'd1,
        CFG_DRIVE_SELECT = 3'd2,
        CFG_READ_COMMAND = 3'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        REG_DRIVE_HEAD = 3'd0,
        REG_SECT_COUNT = 3'd1,
        REG_SECTOR     = 3'd2,
        REG_CYL_LOW    = 3'd3,
        REG_CYL_HIGH   = 3'd4,
        REG_COMMAND    = 3'd5
    } tf_reg_t;

    // Geometry with zero counts already mapped to one
    typedef struct packed {
        logic [DVS_W-1:0] heads;
        logic [DVS_W-1:0] spt;
        logic             drive;
        logic [7:0]       read_command;
    } cfg_t;

    typedef struct packed {
        logic [BLOCK_BITS-1:0] dividend;
        logic [DVS_W-1:0]      aux;
    } div_req_t;

    typedef struct packed {
        logic [BLOCK_BITS-1:0] quot;
        logic [DVS_W-1:0]      rem;
        logic [DVS_W-1:0]      aux;
    } div_res_t;

endpackage

// File: hw/rtl/lcs_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_cfg
// Geometry and command registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module lcs_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lcs_pkg::CFG_DATA_W-1:0]   cfg_data,
    output lcs_pkg::cfg_t                    cfg
);

    logic [4:0] head_count_reg;
    logic [5:0] spt_reg;
    logic       drive_reg;
    logic [7:0] read_cmd_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_count_reg <= lcs_pkg::HEAD_COUNT_RST;
            spt_reg        <= lcs_pkg::SPT_RST;
            drive_reg      <= 1'b0;
            read_cmd_reg   <= lcs_pkg::READ_CMD_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                lcs_pkg::CFG_HEAD_COUNT:   head_count_reg <= cfg_data[4:0];
                lcs_pkg::CFG_SPT:          spt_reg        <= cfg_data[5:0];
                lcs_pkg::CFG_DRIVE_SELECT: drive_reg      <= cfg_data[0];
                lcs_pkg::CFG_READ_COMMAND: read_cmd_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.heads        = (head_count_reg == 5'd0) ? 6'd1 : {1'b0, head_count_reg};
        cfg.spt          = (spt_reg == 6'd0) ? 6'd1 : spt_reg;
        cfg.drive        = drive_reg;
        cfg.read_command = read_cmd_reg;
    end

endmodule

// File: hw/rtl/lcs_divpipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_divpipe
// Pipelined restoring divider: STEP_BITS quotient bits per stage; one request
// may enter every cycle unless the full pipe stalls, each with a side value.
// ----------------------------------------------------------------------------
module lcs_divpipe (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  lcs_pkg::div_req_t             in_req,
    input  logic [lcs_pkg::DVS_W-1:0]     divisor,
    output logic                          out_valid,
    input  logic                          out_ready,
    output lcs_pkg::div_res_t             out_res
);

    localparam int NS = lcs_pkg::DIV_STAGES;
    localparam int PW = lcs_pkg::PAD_W;
    localparam int DW = lcs_pkg::DVS_W;

    logic          valid_reg [NS];
    logic [PW-1:0] work_reg  [NS];
    logic [DW-1:0] rem_reg   [NS];
    logic [DW-1:0] aux_reg   [NS];
    logic          stage_ready [NS];

    assign in_ready = stage_ready[0];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic          v_in;
        logic [PW-1:0] w_in;
        logic [DW-1:0] r_in;
        logic [DW-1:0] a_in;
        logic [PW-1:0] w_next;
        logic [DW-1:0] r_next;
        logic          down_ready;

        if (s == 0) begin : g_first
            assign v_in = in_valid;
            assign w_in = PW'(in_req.dividend);
            assign r_in = '0;
            assign a_in = in_req.aux;
        end else begin : g_mid
            assign v_in = valid_reg[s-1];
            assign w_in = work_reg[s-1];
            assign r_in = rem_reg[s-1];
            assign a_in = aux_reg[s-1];
        end

        if (s == NS - 1) begin : g_last
            assign down_ready = out_ready;
        end else begin : g_inner
            assign down_ready = stage_ready[s+1];
        end

        assign stage_ready[s] = !valid_reg[s] || down_ready;

        // Dividend bits leave at the top, quotient bits enter at the bottom
        always_comb begin
            logic [DW:0]   t;
            logic          q;
            w_next = w_in;
            r_next = r_in;
            for (int k = 0; k < lcs_pkg::STEP_BITS; k++) begin
                t      = {r_next, w_next[PW-1]};
                q      = (t >= {1'b0, divisor});
                w_next = {w_next[PW-2:0], q};
                r_next = q ? DW'(t - {1'b0, divisor}) : t[DW-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else if (stage_ready[s]) begin
                valid_reg[s] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_ready[s] && v_in) begin
                work_reg[s] <= w_next;
                rem_reg[s]  <= r_next;
                aux_reg[s]  <= a_in;
            end
        end
    end

    assign out_valid    = valid_reg[NS-1];
    assign out_res.quot = work_reg[NS-1][lcs_pkg::BLOCK_BITS-1:0];
    assign out_res.rem  = rem_reg[NS-1];
    assign out_res.aux  = aux_reg[NS-1];

endmodule

// File: hw/rtl/lcs_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_seq
// Builds the task-file bytes of one read and emits the six register writes.
// ----------------------------------------------------------------------------
module lcs_seq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lcs_pkg::cfg_t        cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lcs_pkg::div_res_t    in_res,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_register_select,
    output logic [7:0]           m_register_value,
    output logic                 m_out_of_range,
    output logic                 m_last
);

    logic             hold_valid_reg;
    lcs_pkg::tf_reg_t idx_reg;
    logic [7:0]       dh_reg;
    logic [7:0]       sec_reg;
    logic [15:0]      cyl_reg;
    logic             oor_reg;

    logic [31:0]      cyl_wide;
    logic             load;
    logic             is_last;

    assign is_last  = (idx_reg == lcs_pkg::REG_COMMAND);
    // Next request comes in as the command write of the current one leaves
    assign in_ready = !hold_valid_reg || (m_ready && is_last);
    assign load     = in_valid && in_ready;
    assign cyl_wide = 32'(in_res.quot);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            idx_reg        <= lcs_pkg::REG_DRIVE_HEAD;
        end else if (load) begin
            hold_valid_reg <= 1'b1;
            idx_reg        <= lcs_pkg::REG_DRIVE_HEAD;
        end else if (hold_valid_reg && m_ready) begin
            if (is_last) begin
                hold_valid_reg <= 1'b0;
            end else begin
                idx_reg <= lcs_pkg::tf_reg_t'(idx_reg + 3'd1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            dh_reg  <= lcs_pkg::DRVHD_BASE
                     | (lcs_pkg::HEAD_MASK & 8'(in_res.rem))
                     | {3'b000, cfg.drive, 4'b0000};
            sec_reg <= 8'(in_res.aux) + 8'd1;
            cyl_reg <= cyl_wide[15:0];
            oor_reg <= |cyl_wide[31:16];
        end
    end

    always_comb begin
        case (idx_reg)
            lcs_pkg::REG_DRIVE_HEAD: m_register_value = dh_reg;
            lcs_pkg::REG_SECT_COUNT: m_register_value = lcs_pkg::SECTOR_COUNT_ONE;
            lcs_pkg::REG_SECTOR:     m_register_value = sec_reg;
            lcs_pkg::REG_CYL_LOW:    m_register_value = cyl_reg[7:0];
            lcs_pkg::REG_CYL_HIGH:   m_register_value = cyl_reg[15:8];
            lcs_pkg::REG_COMMAND:    m_register_value = cfg.read_command;
            default:                 m_register_value = '0;
        endcase
    end

    assign m_valid           = hold_valid_reg;
    assign m_register_select = idx_reg;
    assign m_out_of_range    = oor_reg;
    assign m_last            = is_last;

    a_step_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=>
            (m_valid && m_register_select == $past(m_register_select) + 3'd1))
        else $error("register writes out of order");

    a_new_starts_at_dh: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=>
            (m_valid && m_register_select == lcs_pkg::REG_DRIVE_HEAD))
        else $error("new request does not start with drive/head");

    a_no_overtake: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !(m_ready && m_last)) |-> !in_ready)
        else $error("request taken before sequence done");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_register_select <= lcs_pkg::REG_COMMAND))
        else $error("register select out of range");

endmodule

// File: hw/rtl/lba_to_chs_read_command.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lba_to_chs_read_command
// Converts a logical block number to cylinder/head/sector and issues the six
// task-file writes of a single-sector read.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake           | payload
//  s_       | in  | s_valid / s_ready   | s_block_number
//  m_       | out | m_valid / m_ready   | m_register_select, m_register_value,
//           |     |                     | m_out_of_range, m_last
//  cfg_     | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Two divider pipelines of DIV_STAGES stages each (7 at 26 bits): block / spt,
// then that quotient / heads. First write appears after a taken request has
// passed both pipelines and the sequencer's holding registers; six writes
// follow, one per cycle while m_ready is high. The single result channel takes
// a new request as the command write of the last one leaves. Reset is
// synchronous: it clears all valid bits and loads the default geometry.
// cfg_ready is always high. With m_ready low the sequencer holds; the divider
// stages fill and then s_ready drops. Nothing is lost or repeated under stalls.
// ----------------------------------------------------------------------------
module lba_to_chs_read_command (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [lcs_pkg::BLOCK_BITS-1:0]      s_block_number,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [2:0]                          m_register_select,
    output logic [7:0]                          m_register_value,
    output logic                                m_out_of_range,
    output logic                                m_last,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lcs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lcs_pkg::CFG_DATA_W-1:0]      cfg_data
);

    lcs_pkg::cfg_t     cfg;
    lcs_pkg::div_req_t spt_req;
    lcs_pkg::div_res_t spt_res;
    lcs_pkg::div_req_t hd_req;
    lcs_pkg::div_res_t hd_res;
    logic              spt_valid;
    logic              spt_ready;
    logic              hd_valid;
    logic              hd_ready;

    lcs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign spt_req.dividend = s_block_number;
    assign spt_req.aux      = '0;

    // block / spt: quotient is the track number, remainder the sector - 1
    lcs_divpipe u_div_spt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_req    (spt_req),
        .divisor   (cfg.spt),
        .out_valid (spt_valid),
        .out_ready (spt_ready),
        .out_res   (spt_res)
    );

    assign hd_req.dividend = spt_res.quot;
    assign hd_req.aux      = spt_res.rem;

    // track / heads: quotient is the cylinder, remainder the head
    lcs_divpipe u_div_heads (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (spt_valid),
        .in_ready  (spt_ready),
        .in_req    (hd_req),
        .divisor   (cfg.heads),
        .out_valid (hd_valid),
        .out_ready (hd_ready),
        .out_res   (hd_res)
    );

    lcs_seq u_seq (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg),
        .in_valid          (hd_valid),
        .in_ready          (hd_ready),
        .in_res            (hd_res),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_register_select (m_register_select),
        .m_register_value  (m_register_value),
        .m_out_of_range    (m_out_of_range),
        .m_last            (m_last)
    );

endmodule

// File: sim/lba_to_chs_read_command_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lba_to_chs_read_command_tb
// Drives block numbers through the LBA to CHS sequencer under several drive
// geometries and checks every task-file write against a local CHS predictor.
// ----------------------------------------------------------------------------
module lba_to_chs_read_command_tb;

    localparam int          RANDOM_PHASES   = 8;
    localparam int          ITEMS_PER_PHASE = 38;
    localparam int          TAIL_CYCLES     = 2 * lcs_pkg::DIV_STAGES + 12;
    localparam int          DRAIN_LIMIT     = 5000;
    localparam logic [lcs_pkg::BLOCK_BITS-1:0] LBA_MAX = {lcs_pkg::BLOCK_BITS{1'b1}};

    typedef struct packed {
        lcs_pkg::tf_reg_t sel;
        logic [7:0]       value;
        logic             oor;
        logic             last;
    } tf_write_t;

    logic                               aclk = 1'b0;
    logic                               aresetn = 1'b0;
    logic                               s_valid = 1'b0;
    logic                               s_ready;
    logic [lcs_pkg::BLOCK_BITS-1:0]     s_block_number = '0;
    logic                               m_valid;
    logic                               m_ready = 1'b0;
    logic [2:0]                         m_register_select;
    logic [7:0]                         m_register_value;
    logic                               m_out_of_range;
    logic                               m_last;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [lcs_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [lcs_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

    // geometry as the block should hold it
    logic [4:0]             geo_heads = lcs_pkg::HEAD_COUNT_RST;
    logic [5:0]             geo_spt = lcs_pkg::SPT_RST;
    logic                   geo_drive = 1'b0;
    logic [7:0]             geo_cmd = lcs_pkg::READ_CMD_RST;

    logic [lcs_pkg::BLOCK_BITS-1:0] lba_queue[$];
    tf_write_t              pending_writes[$];
    int                     mismatch_count = 0;
    bit                     calm = 1'b0;

    lba_to_chs_read_command uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_block_number    (s_block_number),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_register_select (m_register_select),
        .m_register_value  (m_register_value),
        .m_out_of_range    (m_out_of_range),
        .m_last            (m_last),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always #5 aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // CHS conversion and the six task-file writes of one request
    function automatic void predict_task_file(input logic [lcs_pkg::BLOCK_BITS-1:0] blk);
        logic [31:0] heads;
        logic [31:0] spt;
        logic [31:0] cyl;
        logic [31:0] head;
        logic [31:0] sector;
        logic        oor;
        heads  = (geo_heads == '0) ? 32'd1 : 32'(geo_heads);
        spt    = (geo_spt == '0) ? 32'd1 : 32'(geo_spt);
        cyl    = 32'(blk) / (heads * spt);
        head   = (32'(blk) / spt) % heads;
        sector = 32'(blk) % spt + 32'd1;
        oor    = (cyl > 32'd65535);
        pending_writes.push_back('{lcs_pkg::REG_DRIVE_HEAD,
            lcs_pkg::DRVHD_BASE | (head[7:0] & lcs_pkg::HEAD_MASK)
                | {3'b000, geo_drive, 4'b0000},
            oor, 1'b0});
        pending_writes.push_back('{lcs_pkg::REG_SECT_COUNT, lcs_pkg::SECTOR_COUNT_ONE,
            oor, 1'b0});
        pending_writes.push_back('{lcs_pkg::REG_SECTOR, sector[7:0], oor, 1'b0});
        pending_writes.push_back('{lcs_pkg::REG_CYL_LOW, cyl[7:0], oor, 1'b0});
        pending_writes.push_back('{lcs_pkg::REG_CYL_HIGH, cyl[15:8], oor, 1'b0});
        pending_writes.push_back('{lcs_pkg::REG_COMMAND, geo_cmd, oor, 1'b1});
    endfunction

    // Block numbers biased toward track, cylinder and overflow boundaries
    function automatic logic [lcs_pkg::BLOCK_BITS-1:0] pick_block();
        logic [63:0] heads;
        logic [63:0] spt;
        logic [63:0] hs;
        logic [63:0] lba;
        heads = (geo_heads == '0) ? 64'd1 : 64'(geo_heads);
        spt   = (geo_spt == '0) ? 64'd1 : 64'(geo_spt);
        hs    = heads * spt;
        case ($urandom_range(9))
            0, 1, 2, 3: lba = 64'($urandom);
            4, 5:       lba = 64'($urandom_range(4095));
            6, 7: begin
                lba = 64'd65536 * hs + 64'($urandom_range(32'(2 * hs))) - hs;
                if (lba > 64'(LBA_MAX))
                    lba = 64'(LBA_MAX) - 64'($urandom_range(32'(2 * hs)));
            end
            default: begin
                lba = 64'($urandom_range(2047)) * hs;
                case ($urandom_range(3))
                    0:       lba = lba;
                    1:       lba = lba + spt - 1;
                    2:       lba = lba + spt;
                    default: lba = lba + hs - 1;
                endcase
            end
        endcase
        return lba[lcs_pkg::BLOCK_BITS-1:0];
    endfunction

    task automatic write_geometry_reg(input logic [lcs_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [lcs_pkg::CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        case (idx)
            lcs_pkg::CFG_HEAD_COUNT:   geo_heads = data[4:0];
            lcs_pkg::CFG_SPT:          geo_spt   = data[5:0];
            lcs_pkg::CFG_DRIVE_SELECT: geo_drive = data[0];
            lcs_pkg::CFG_READ_COMMAND: geo_cmd   = data;
            default: ;
        endcase
    endtask

    // Hold off until every request is in and every write has come back
    task automatic drain();
        int guard;
        guard = 0;
        while (lba_queue.size() != 0 || s_valid) @(posedge aclk);
        while (pending_writes.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // Request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                predict_task_file(s_block_number);
            if (!s_valid || s_ready) begin
                if (lba_queue.size() != 0 && (calm || $urandom_range(99) >= 17)) begin
                    s_valid        <= 1'b1;
                    s_block_number <= lba_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        tf_write_t exp_w;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= 17);
            if (m_valid && m_ready) begin
                if (pending_writes.size() == 0) begin
                    report_mismatch($sformatf("unexpected write sel=%0d val=%02h",
                        m_register_select, m_register_value));
                end else begin
                    exp_w = pending_writes.pop_front();
                    if (m_register_select !== exp_w.sel)
                        report_mismatch($sformatf("register_select %0d, expected %0d",
                            m_register_select, exp_w.sel));
                    if (m_register_value !== exp_w.value)
                        report_mismatch($sformatf("register_value %02h, expected %02h (sel %0d)",
                            m_register_value, exp_w.value, exp_w.sel));
                    if (m_out_of_range !== exp_w.oor)
                        report_mismatch($sformatf("out_of_range %b, expected %b (sel %0d)",
                            m_out_of_range, exp_w.oor, exp_w.sel));
                    if (m_last !== exp_w.last)
                        report_mismatch($sformatf("last %b, expected %b (sel %0d)",
                            m_last, exp_w.last, exp_w.sel));
                end
            end
        end
    end

    initial begin
        int i;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // default geometry 16 heads x 63 sectors, cylinder rollover at 65536
        lba_queue.push_back(26'd0);
        lba_queue.push_back(26'd62);
        lba_queue.push_back(26'd63);
        lba_queue.push_back(26'd1007);
        lba_queue.push_back(26'd1008);
        lba_queue.push_back(26'd66060287);
        lba_queue.push_back(26'd66060288);
        lba_queue.push_back(LBA_MAX);
        drain();

        // smallest geometry, slave drive; unused indexes must not disturb it
        write_geometry_reg(lcs_pkg::CFG_HEAD_COUNT, 8'h01);
        write_geometry_reg(lcs_pkg::CFG_SPT, 8'h01);
        write_geometry_reg(lcs_pkg::CFG_DRIVE_SELECT, 8'h01);
        write_geometry_reg(lcs_pkg::CFG_READ_COMMAND, 8'hFF);
        for (i = int'(lcs_pkg::CFG_READ_COMMAND) + 1; i < (1 << lcs_pkg::CFG_IDX_W);
             i++) begin
            write_geometry_reg(i[lcs_pkg::CFG_IDX_W-1:0], 8'hFF);
            write_geometry_reg(i[lcs_pkg::CFG_IDX_W-1:0], 8'h00);
        end
        lba_queue.push_back(26'd0);
        lba_queue.push_back(26'd65535);
        lba_queue.push_back(26'd65536);
        lba_queue.push_back(LBA_MAX);
        drain();

        // zero counts behave as one; upper data bits are dropped
        write_geometry_reg(lcs_pkg::CFG_HEAD_COUNT, 8'hE0);
        write_geometry_reg(lcs_pkg::CFG_SPT, 8'hC0);
        write_geometry_reg(lcs_pkg::CFG_DRIVE_SELECT, 8'hFE);
        write_geometry_reg(lcs_pkg::CFG_READ_COMMAND, 8'h00);
        lba_queue.push_back(26'd1);
        lba_queue.push_back(26'd65536);
        lba_queue.push_back(LBA_MAX);
        drain();

        // head counts above 16: only the low head nibble reaches the byte
        write_geometry_reg(lcs_pkg::CFG_HEAD_COUNT, 8'h1F);
        write_geometry_reg(lcs_pkg::CFG_SPT, 8'h3F);
        write_geometry_reg(lcs_pkg::CFG_DRIVE_SELECT, 8'h01);
        write_geometry_reg(lcs_pkg::CFG_READ_COMMAND, 8'hC4);
        lba_queue.push_back(26'd0);
        lba_queue.push_back(26'd1007);
        lba_queue.push_back(26'd1008);
        lba_queue.push_back(26'd1952);
        lba_queue.push_back(26'd1953);
        lba_queue.push_back(LBA_MAX);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_geometry_reg(lcs_pkg::CFG_HEAD_COUNT, ($urandom_range(3) == 0) ?
                8'($urandom) : 8'($urandom_range(1, 16)));
            write_geometry_reg(lcs_pkg::CFG_SPT, ($urandom_range(3) == 0) ?
                8'($urandom) : 8'($urandom_range(1, 63)));
            write_geometry_reg(lcs_pkg::CFG_DRIVE_SELECT, 8'($urandom));
            write_geometry_reg(lcs_pkg::CFG_READ_COMMAND, 8'($urandom));
            if ($urandom_range(1) == 1)
                write_geometry_reg(lcs_pkg::CFG_IDX_W'($urandom_range(
                    int'(lcs_pkg::CFG_READ_COMMAND) + 1,
                    (1 << lcs_pkg::CFG_IDX_W) - 1)), 8'($urandom));
            calm = (p == 2);
            repeat (ITEMS_PER_PHASE) lba_queue.push_back(pick_block());
            drain();
        end
        calm = 1'b0;

        if (pending_writes.size() != 0)
            report_mismatch($sformatf("%0d writes never arrived", pending_writes.size()));
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
